// File: rtl/scpgm_pkg.sv
package scpgm_pkg;

  localparam int unsigned PanTableDepthDef = 256;
  localparam int unsigned MaxBlockLenDef   = 4096;

  // field widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned BusW     = 28;
  localparam int unsigned GainW    = 16;
  localparam int unsigned PanW     = 16;
  localparam int unsigned CoeffW   = 17;
  localparam int unsigned DecayW   = 16;
  localparam int unsigned LenW     = 13;
  localparam int unsigned RecipW   = 17;
  localparam int unsigned MeterW   = 17;
  localparam int unsigned RampW    = 24;
  localparam int unsigned TabW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 80;

  // shared multiplier operands
  localparam int unsigned MulAW = 25;
  localparam int unsigned MulBW = 25;
  localparam int unsigned MulPW = MulAW + MulBW;

  // register reset values
  localparam logic [GainW-1:0]         TargetGainRst = 16'd13107;
  localparam logic signed [PanW-1:0]   TargetPanRst  = 16'sd0;
  localparam logic [CoeffW-1:0]        SmoothRst     = 17'd65536;
  localparam logic [DecayW-1:0]        DecayRst      = 16'd65470;
  localparam logic [LenW-1:0]          BlockLenRst   = 13'd512;
  localparam logic [RecipW-1:0]        RecipRst      = 17'd128;

  // limits
  localparam logic [CoeffW-1:0] CoeffMin = 17'd3277;
  localparam logic [CoeffW-1:0] CoeffMax = 17'd65536;
  localparam logic [DecayW-1:0] DecayMin = 16'd32768;
  localparam logic [DecayW-1:0] DecayMax = 16'd65470;
  localparam logic [RecipW-1:0] RecipMax = 17'd65536;
  localparam int unsigned       PanRound = 32767;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_GAIN,
    CFG_TARGET_PAN,
    CFG_SMOOTH_COEFF,
    CFG_METER_DECAY,
    CFG_BLOCK_LEN,
    CFG_BLOCK_LEN_RECIP,
    CFG_MONO_SOURCE,
    CFG_BUS_STEREO
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_IDX_S,
    S_DIV_S,
    S_ROM_S,
    S_GL_S,
    S_GR_S,
    S_SM_G,
    S_SM_P,
    S_PAN_U,
    S_IDX_E,
    S_DIV_E,
    S_ROM_E,
    S_GL_E,
    S_GR_E,
    S_ST_L,
    S_ST_R,
    S_ST_C,
    S_MUL_L,
    S_MUL_R,
    S_FIN,
    S_MET
  } state_e;

  typedef struct packed {
    logic                     en;
    logic signed [MulAW-1:0]  a;
    logic signed [MulBW-1:0]  b;
  } mul_req_t;

endpackage

// File: rtl/scpgm_mul.sv
module scpgm_mul (
  input  logic                                    clk_i,
  input  scpgm_pkg::mul_req_t                     req_i,
  output logic signed [scpgm_pkg::MulPW-1:0]      prod_o
);

  logic signed [scpgm_pkg::MulPW-1:0] prod_q;

  // product holds until the next issue
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/scpgm_pan_rom.sv
module scpgm_pan_rom #(
  parameter int unsigned PanTableDepth = scpgm_pkg::PanTableDepthDef
) (
  input  logic                               clk_i,
  input  logic [$clog2(PanTableDepth)-1:0]   idx_i,
  output logic [scpgm_pkg::TabW-1:0]         tab_l_o,
  output logic [scpgm_pkg::TabW-1:0]         tab_r_o
);

  localparam int unsigned PanIdxW = $clog2(PanTableDepth);
  localparam int unsigned PanLast = PanTableDepth - 1;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned OneQ30    = 64'd1073741824;

  // Taylor series of sin, Horner form, Q30; rounded to Q15
  function automatic logic [scpgm_pkg::TabW-1:0] sine_q15(longint unsigned t);
    longint unsigned t2;
    longint unsigned r;
    longint unsigned s;
    t2 = (t * t) >> 30;
    r  = OneQ30;
    r  = OneQ30 - ((t2 * r) >> 30) / 110;
    r  = OneQ30 - ((t2 * r) >> 30) / 72;
    r  = OneQ30 - ((t2 * r) >> 30) / 42;
    r  = OneQ30 - ((t2 * r) >> 30) / 20;
    r  = OneQ30 - ((t2 * r) >> 30) / 6;
    s  = (((t * r) >> 30) + 16384) >> 15;
    if (s > 32768) begin
      s = 32768;
    end
    return scpgm_pkg::TabW'(s);
  endfunction

  logic [scpgm_pkg::TabW-1:0] pan_tab [PanTableDepth];
  logic [scpgm_pkg::TabW-1:0] tab_l_q;
  logic [scpgm_pkg::TabW-1:0] tab_r_q;
  logic [PanIdxW-1:0]         idx_mirror;

  for (genvar k = 0; k < PanTableDepth; k++) begin : g_tab
    localparam longint unsigned Ang = (longint'(k) * HalfPiQ30) / (PanTableDepth - 1);
    localparam logic [scpgm_pkg::TabW-1:0] Val = sine_q15(Ang);
    assign pan_tab[k] = Val;
  end

  // left gain reads the mirrored entry
  assign idx_mirror = PanIdxW'(PanLast) - idx_i;

  always_ff @(posedge clk_i) begin
    tab_l_q <= pan_tab[idx_mirror];
    tab_r_q <= pan_tab[idx_i];
  end

  assign tab_l_o = tab_l_q;
  assign tab_r_o = tab_r_q;

endmodule

// File: rtl/stereo_channel_pan_gain_mixer_top.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: in_left, in_right, bus_left, bus_right
// m_axis    out  tvalid/tready           tdata: bus_left_out, bus_right_out, meter_level
//                                        tlast: block_end
// cfg       in   cfg_we_i (no back-pressure)  cfg_idx_i, cfg_data_i
//
// Most words run accept, left multiply, right multiply, result load.
// The first word of a block also runs gain/pan smoothing, two table look-ups,
// four gain products and two ramp steps; the last word of a block also runs
// the meter decay. All of it runs through one 25x25 multiplier.
// Async active-low reset; no clearing pass. A held result stalls the last step only;
// a new word is taken while the previous result waits.
module stereo_channel_pan_gain_mixer_top #(
  parameter int unsigned PanTableDepth = scpgm_pkg::PanTableDepthDef,
  parameter int unsigned MaxBlockLen   = scpgm_pkg::MaxBlockLenDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] in_left, [47:24] in_right, [75:48] bus_left, [103:76] bus_right
  input  logic [scpgm_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [27:0] bus_left_out, [55:28] bus_right_out, [72:56] meter_level, [79:73] zero
  output logic [scpgm_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [scpgm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [scpgm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned PanIdxW = $clog2(PanTableDepth);
  localparam int unsigned PanLast = PanTableDepth - 1;
  localparam int unsigned IdxW    = $clog2(MaxBlockLen);
  localparam int unsigned CmpW    = (IdxW + 1 > scpgm_pkg::LenW) ? IdxW + 1 : scpgm_pkg::LenW;
  localparam int unsigned AW      = scpgm_pkg::MulAW;
  localparam int unsigned BW      = scpgm_pkg::MulBW;
  localparam int unsigned PW      = scpgm_pkg::MulPW;
  localparam int unsigned SW      = scpgm_pkg::SampleW;
  localparam int unsigned BusW    = scpgm_pkg::BusW;
  localparam int unsigned RampW   = scpgm_pkg::RampW;
  localparam int unsigned MeterW  = scpgm_pkg::MeterW;
  localparam int unsigned OutPadW = scpgm_pkg::OutDataW - 2 * BusW - MeterW;

  // configuration
  logic [scpgm_pkg::GainW-1:0]        tgt_gain_q;
  logic signed [scpgm_pkg::PanW-1:0]  tgt_pan_q;
  logic [scpgm_pkg::CoeffW-1:0]       smooth_q;
  logic [scpgm_pkg::DecayW-1:0]       decay_q;
  logic [scpgm_pkg::LenW-1:0]         blen_q;
  logic [scpgm_pkg::RecipW-1:0]       recip_q;
  logic                               mono_q;
  logic                               stereo_q;

  // sequencer and channel state
  scpgm_pkg::state_e                  state_q, state_d;
  logic [scpgm_pkg::GainW-1:0]        cur_gain_q, cur_gain_d;
  logic signed [scpgm_pkg::PanW-1:0]  cur_pan_q, cur_pan_d;
  logic [RampW-1:0]                   rgl_q, rgl_d, rgr_q, rgr_d;
  logic signed [RampW-1:0]            stl_q, stl_d, str_q, str_d;
  logic [IdxW-1:0]                    sidx_q, sidx_d;
  logic [MeterW-1:0]                  bpeak_q, bpeak_d;
  logic [MeterW-1:0]                  meter_q, meter_d;
  logic                               m_tvalid_q, m_tvalid_d;

  // working registers
  logic signed [SW-1:0]               in_l_q, in_r_q;
  logic signed [BusW-1:0]             bus_l_q, bus_r_q;
  logic [PanIdxW-1:0]                 pidx_q, pidx_d;
  logic [RampW-1:0]                   endl_q, endl_d, endr_q, endr_d;
  logic signed [BusW-1:0]             resl_q, resl_d, resr_q, resr_d;
  logic [scpgm_pkg::OutDataW-1:0]     m_tdata_q, m_tdata_d;
  logic                               m_tlast_q, m_tlast_d;

  logic                               in_acc;
  logic                               out_free;
  logic                               out_load;
  logic                               end_hit;
  scpgm_pkg::mul_req_t                mreq;
  logic signed [PW-1:0]               prod;
  logic [scpgm_pkg::TabW-1:0]         tab_l, tab_r;

  logic [scpgm_pkg::CoeffW-1:0]       coeff_c;
  logic [scpgm_pkg::RecipW-1:0]       recip_c;
  logic [scpgm_pkg::DecayW-1:0]       decay_c;
  logic [scpgm_pkg::PanW-1:0]         pan_u;
  logic signed [16:0]                 dgain, dpan;
  logic signed [19:0]                 gsum, psum;
  logic [scpgm_pkg::GainW-1:0]        gain_sm;
  logic signed [scpgm_pkg::PanW-1:0]  pan_sm;
  logic [28:0]                        px, pq_sum;
  logic [12:0]                        pq;
  logic [PanIdxW-1:0]                 pidx_new;
  logic [RampW-1:0]                   gain_new;
  logic signed [33:0]                 step_raw;
  logic signed [RampW-1:0]            step_new;
  logic signed [BusW-1:0]             vs;
  logic [MeterW-1:0]                  vpeak;
  logic signed [BusW-1:0]             sat_l, sat_r;
  logic [RampW-1:0]                   rgl_next, rgr_next;

  function automatic logic signed [BusW-1:0] sat_bus(logic signed [BusW:0] s);
    logic signed [BusW:0] hi;
    logic signed [BusW:0] lo;
    hi = (BusW + 1)'((2 ** (BusW - 1)) - 1);
    lo = -hi - (BusW + 1)'(1);
    if (s > hi) begin
      return hi[BusW-1:0];
    end else if (s < lo) begin
      return lo[BusW-1:0];
    end
    return s[BusW-1:0];
  endfunction

  // |v| held at 1.0 (Q.23), then to Q1.16
  function automatic logic [MeterW-1:0] peak_of(logic signed [BusW-1:0] v);
    logic [BusW-1:0] a;
    a = v[BusW-1] ? BusW'(-v) : BusW'(v);
    if (a > BusW'(2 ** 23)) begin
      a = BusW'(2 ** 23);
    end
    return a[23:7];
  endfunction

  function automatic logic [RampW-1:0] ramp_add(logic [RampW-1:0] g,
                                                 logic signed [RampW-1:0] st);
    logic signed [RampW+1:0] s;
    s = $signed({2'b00, g}) + (RampW + 2)'(st);
    if (s < 0) begin
      return '0;
    end else if (s[RampW]) begin
      return '1;
    end
    return s[RampW-1:0];
  endfunction

  scpgm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (prod)
  );

  scpgm_pan_rom #(
    .PanTableDepth (PanTableDepth)
  ) u_pan_rom (
    .clk_i   (clk_i),
    .idx_i   (pidx_q),
    .tab_l_o (tab_l),
    .tab_r_o (tab_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_gain_q <= scpgm_pkg::TargetGainRst;
      tgt_pan_q  <= scpgm_pkg::TargetPanRst;
      smooth_q   <= scpgm_pkg::SmoothRst;
      decay_q    <= scpgm_pkg::DecayRst;
      blen_q     <= scpgm_pkg::BlockLenRst;
      recip_q    <= scpgm_pkg::RecipRst;
      mono_q     <= 1'b0;
      stereo_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (scpgm_pkg::cfg_idx_e'(cfg_idx_i))
        scpgm_pkg::CFG_TARGET_GAIN:     tgt_gain_q <= cfg_data_i[15:0];
        scpgm_pkg::CFG_TARGET_PAN:      tgt_pan_q  <= $signed(cfg_data_i[15:0]);
        scpgm_pkg::CFG_SMOOTH_COEFF:    smooth_q   <= cfg_data_i;
        scpgm_pkg::CFG_METER_DECAY:     decay_q    <= cfg_data_i[15:0];
        scpgm_pkg::CFG_BLOCK_LEN:       blen_q     <= cfg_data_i[12:0];
        scpgm_pkg::CFG_BLOCK_LEN_RECIP: recip_q    <= cfg_data_i;
        scpgm_pkg::CFG_MONO_SOURCE:     mono_q     <= cfg_data_i[0];
        scpgm_pkg::CFG_BUS_STEREO:      stereo_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == scpgm_pkg::S_IDLE);
  assign out_free      = !m_tvalid_q || m_axis_tready;

  // clamped coefficients
  assign coeff_c = (smooth_q < scpgm_pkg::CoeffMin) ? scpgm_pkg::CoeffMin :
                   (smooth_q > scpgm_pkg::CoeffMax) ? scpgm_pkg::CoeffMax : smooth_q;
  assign recip_c = (recip_q > scpgm_pkg::RecipMax) ? scpgm_pkg::RecipMax : recip_q;
  assign decay_c = (decay_q < scpgm_pkg::DecayMin) ? scpgm_pkg::DecayMin :
                   (decay_q > scpgm_pkg::DecayMax) ? scpgm_pkg::DecayMax : decay_q;

  // pan + 1.0 as an unsigned word
  assign pan_u = {~cur_pan_q[scpgm_pkg::PanW-1], cur_pan_q[scpgm_pkg::PanW-2:0]};
  assign dgain = $signed({1'b0, tgt_gain_q}) - $signed({1'b0, cur_gain_q});
  assign dpan  = 17'(tgt_pan_q) - 17'(cur_pan_q);

  // smoothing results, product >>> 16
  assign gsum    = 20'($signed({1'b0, cur_gain_q})) + 20'($signed(prod[34:16]));
  assign psum    = 20'(cur_pan_q) + 20'($signed(prod[34:16]));
  assign gain_sm = (gsum < 0) ? '0 : (gsum > 20'sd65535) ? '1 : gsum[15:0];
  assign pan_sm  = (psum < -20'sd32768) ? 16'sh8000 :
                   (psum > 20'sd32767) ? 16'sh7fff : psum[15:0];

  // rounded divide by 65535: q = (x + (x >> 16) + 1) >> 16
  assign px       = 29'(prod[27:0]) + 29'(scpgm_pkg::PanRound);
  assign pq_sum   = px + (px >> 16) + 29'd1;
  assign pq       = pq_sum[28:16];
  assign pidx_new = (pq > 13'(PanLast)) ? PanIdxW'(PanLast) : pq[PanIdxW-1:0];

  assign gain_new = prod[30:7];
  assign step_raw = $signed(prod[49:16]);
  assign step_new = (step_raw > 34'sd8388607) ? 24'sh7fffff :
                    (step_raw < -34'sd8388608) ? 24'sh800000 : step_raw[23:0];

  assign vs    = $signed(prod[49:22]);
  assign vpeak = peak_of(vs);
  assign sat_l = sat_bus((BusW + 1)'(bus_l_q) + (BusW + 1)'(vs));
  assign sat_r = sat_bus((BusW + 1)'(bus_r_q) + (BusW + 1)'(vs));

  assign rgl_next = ramp_add(rgl_q, stl_q);
  assign rgr_next = ramp_add(rgr_q, str_q);

  assign end_hit = (CmpW'(sidx_q) + CmpW'(1) >= CmpW'(blen_q)) ||
                   (CmpW'(sidx_q) + CmpW'(1) >= CmpW'(MaxBlockLen));

  always_comb begin
    state_d    = state_q;
    cur_gain_d = cur_gain_q;
    cur_pan_d  = cur_pan_q;
    rgl_d      = rgl_q;
    rgr_d      = rgr_q;
    stl_d      = stl_q;
    str_d      = str_q;
    sidx_d     = sidx_q;
    bpeak_d    = bpeak_q;
    meter_d    = meter_q;
    pidx_d     = pidx_q;
    endl_d     = endl_q;
    endr_d     = endr_q;
    resl_d     = resl_q;
    resr_d     = resr_q;
    m_tdata_d  = m_tdata_q;
    m_tlast_d  = m_tlast_q;
    out_load   = 1'b0;
    mreq       = '0;

    case (state_q)
      scpgm_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (sidx_q == '0) ? scpgm_pkg::S_IDX_S : scpgm_pkg::S_MUL_L;
        end
      end
      // start-of-block gains from the old gain and pan
      scpgm_pkg::S_IDX_S: begin
        mreq    = '{en: 1'b1, a: AW'(pan_u), b: BW'(PanLast)};
        state_d = scpgm_pkg::S_DIV_S;
      end
      scpgm_pkg::S_DIV_S: begin
        pidx_d  = pidx_new;
        state_d = scpgm_pkg::S_ROM_S;
      end
      scpgm_pkg::S_ROM_S: begin
        state_d = scpgm_pkg::S_GL_S;
      end
      scpgm_pkg::S_GL_S: begin
        mreq    = '{en: 1'b1, a: AW'(tab_l), b: BW'(cur_gain_q)};
        state_d = scpgm_pkg::S_GR_S;
      end
      scpgm_pkg::S_GR_S: begin
        rgl_d   = gain_new;
        mreq    = '{en: 1'b1, a: AW'(tab_r), b: BW'(cur_gain_q)};
        state_d = scpgm_pkg::S_SM_G;
      end
      scpgm_pkg::S_SM_G: begin
        rgr_d   = gain_new;
        mreq    = '{en: 1'b1, a: AW'(dgain), b: BW'(coeff_c)};
        state_d = scpgm_pkg::S_SM_P;
      end
      scpgm_pkg::S_SM_P: begin
        cur_gain_d = gain_sm;
        mreq       = '{en: 1'b1, a: AW'(dpan), b: BW'(coeff_c)};
        state_d    = scpgm_pkg::S_PAN_U;
      end
      scpgm_pkg::S_PAN_U: begin
        cur_pan_d = pan_sm;
        state_d   = scpgm_pkg::S_IDX_E;
      end
      // end-of-block gains from the smoothed values
      scpgm_pkg::S_IDX_E: begin
        mreq    = '{en: 1'b1, a: AW'(pan_u), b: BW'(PanLast)};
        state_d = scpgm_pkg::S_DIV_E;
      end
      scpgm_pkg::S_DIV_E: begin
        pidx_d  = pidx_new;
        state_d = scpgm_pkg::S_ROM_E;
      end
      scpgm_pkg::S_ROM_E: begin
        state_d = scpgm_pkg::S_GL_E;
      end
      scpgm_pkg::S_GL_E: begin
        mreq    = '{en: 1'b1, a: AW'(tab_l), b: BW'(cur_gain_q)};
        state_d = scpgm_pkg::S_GR_E;
      end
      scpgm_pkg::S_GR_E: begin
        endl_d  = gain_new;
        mreq    = '{en: 1'b1, a: AW'(tab_r), b: BW'(cur_gain_q)};
        state_d = scpgm_pkg::S_ST_L;
      end
      scpgm_pkg::S_ST_L: begin
        endr_d  = gain_new;
        mreq    = '{en: 1'b1,
                    a: AW'($signed({1'b0, endl_q}) - $signed({1'b0, rgl_q})),
                    b: BW'(recip_c)};
        state_d = scpgm_pkg::S_ST_R;
      end
      scpgm_pkg::S_ST_R: begin
        stl_d   = step_new;
        mreq    = '{en: 1'b1,
                    a: AW'($signed({1'b0, endr_q}) - $signed({1'b0, rgr_q})),
                    b: BW'(recip_c)};
        state_d = scpgm_pkg::S_ST_C;
      end
      scpgm_pkg::S_ST_C: begin
        str_d   = step_new;
        mreq    = '{en: 1'b1, a: AW'(in_l_q), b: BW'(rgl_q)};
        state_d = scpgm_pkg::S_MUL_R;
      end
      // per-word mixing
      scpgm_pkg::S_MUL_L: begin
        mreq    = '{en: 1'b1, a: AW'(in_l_q), b: BW'(rgl_q)};
        state_d = scpgm_pkg::S_MUL_R;
      end
      scpgm_pkg::S_MUL_R: begin
        resl_d  = sat_l;
        bpeak_d = (vpeak > bpeak_q) ? vpeak : bpeak_q;
        mreq    = '{en: 1'b1, a: AW'(in_r_q), b: BW'(rgr_q)};
        state_d = scpgm_pkg::S_FIN;
      end
      scpgm_pkg::S_FIN: begin
        if (end_hit || out_free) begin
          resr_d = stereo_q ? sat_r : bus_r_q;
          if (stereo_q && (vpeak > bpeak_q)) begin
            bpeak_d = vpeak;
          end
          rgl_d = rgl_next;
          rgr_d = rgr_next;
          if (end_hit) begin
            sidx_d  = '0;
            mreq    = '{en: 1'b1, a: AW'(meter_q), b: BW'(decay_c)};
            state_d = scpgm_pkg::S_MET;
          end else begin
            sidx_d    = sidx_q + IdxW'(1);
            out_load  = 1'b1;
            m_tdata_d = {OutPadW'(0), meter_q, resr_d, resl_q};
            m_tlast_d = 1'b0;
            state_d   = scpgm_pkg::S_IDLE;
          end
        end
      end
      scpgm_pkg::S_MET: begin
        if (out_free) begin
          meter_d   = (bpeak_q > meter_q) ? bpeak_q : prod[32:16];
          bpeak_d   = '0;
          out_load  = 1'b1;
          m_tdata_d = {OutPadW'(0), meter_d, resr_q, resl_q};
          m_tlast_d = 1'b1;
          state_d   = scpgm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = scpgm_pkg::S_IDLE;
      end
    endcase
  end

  assign m_tvalid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_tvalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= scpgm_pkg::S_IDLE;
      cur_gain_q <= '0;
      cur_pan_q  <= '0;
      rgl_q      <= '0;
      rgr_q      <= '0;
      stl_q      <= '0;
      str_q      <= '0;
      sidx_q     <= '0;
      bpeak_q    <= '0;
      meter_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_gain_q <= cur_gain_d;
      cur_pan_q  <= cur_pan_d;
      rgl_q      <= rgl_d;
      rgr_q      <= rgr_d;
      stl_q      <= stl_d;
      str_q      <= str_d;
      sidx_q     <= sidx_d;
      bpeak_q    <= bpeak_d;
      meter_q    <= meter_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_l_q  <= $signed(s_axis_tdata[23:0]);
      in_r_q  <= mono_q ? $signed(s_axis_tdata[23:0]) : $signed(s_axis_tdata[47:24]);
      bus_l_q <= $signed(s_axis_tdata[75:48]);
      bus_r_q <= $signed(s_axis_tdata[103:76]);
    end
    pidx_q    <= pidx_d;
    endl_q    <= endl_d;
    endr_q    <= endr_d;
    resl_q    <= resl_d;
    resr_q    <= resr_d;
    m_tdata_q <= m_tdata_d;
    m_tlast_q <= m_tlast_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in work");

  a_block_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scpgm_pkg::S_IDX_S) |-> (sidx_q == '0))
    else $error("block start sequence away from sample index zero");

  a_block_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scpgm_pkg::S_MET && out_free) |=>
      (sidx_q == '0 && bpeak_q == '0 && m_axis_tvalid && m_axis_tlast))
    else $error("block end did not wrap index and peak");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scpgm_pkg::S_FIN && !end_hit && out_free) |=>
      (m_axis_tvalid && !m_axis_tlast && s_axis_tready))
    else $error("result word not presented after mixing");

endmodule

// File: tb/sv/tb_stereo_channel_pan_gain_mixer_top.sv
module tb_stereo_channel_pan_gain_mixer_top;
  import scpgm_pkg::*;

  localparam int unsigned PanD       = PanTableDepthDef;
  localparam longint      QuarterQ30 = 64'd1686629713;
  localparam longint      OneQ30     = 64'd1 << 30;
  localparam longint      BusMax     = 134217727;
  localparam int          SettleCyc  = 32;
  localparam int          StallLimit = 4000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [BusW-1:0]   bus_l;
    logic [BusW-1:0]   bus_r;
    logic              blk_end;
    logic [MeterW-1:0] meter;
  } mix_result_t;

  typedef struct packed {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CfgDataW-1:0]   cfg_val;
    logic [SampleW-1:0]    inl;
    logic [SampleW-1:0]    inr;
    logic [BusW-1:0]       bl;
    logic [BusW-1:0]       br;
    logic                  chk;
    mix_result_t           want;
  } step_row_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  stereo_channel_pan_gain_mixer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // register shadow
  longint tgt_gain   = TargetGainRst;
  longint tgt_pan    = 0;
  longint smooth     = SmoothRst;
  longint decay      = DecayRst;
  longint blen       = BlockLenRst;
  longint recip      = RecipRst;
  bit     mono_src   = 1'b0;
  bit     stereo_bus = 1'b1;

  // channel state
  longint gain_now, pan_now, ramp_l, ramp_r, step_l, step_r;
  longint pos_in_block, peak_blk, meter_now;
  int unsigned pan_tab [PanD];

  mix_result_t bus_exp_q [$];
  step_row_t   dir_tab [$];
  int          err_cnt;
  int          send_idle_pct;
  int          rcv_idle_pct;
  int          quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // quarter sine, Q30 Taylor series evaluated in nested form
  function automatic void build_pan_tab();
    longint unsigned t, t2, r, s;
    for (int k = 0; k < PanD; k++) begin
      t  = (longint'(k) * QuarterQ30) / (PanD - 1);
      t2 = (t * t) >> 30;
      r  = OneQ30;
      r  = OneQ30 - ((t2 * r) >> 30) / 110;
      r  = OneQ30 - ((t2 * r) >> 30) / 72;
      r  = OneQ30 - ((t2 * r) >> 30) / 42;
      r  = OneQ30 - ((t2 * r) >> 30) / 20;
      r  = OneQ30 - ((t2 * r) >> 30) / 6;
      s  = (((t * r) >> 30) + 16384) >> 15;
      pan_tab[k] = 32'((s > 32768) ? 32768 : s);
    end
  endfunction

  function automatic void pan_pair(input longint pan, input longint gain,
                                   output longint gl, output longint gr);
    longint idx;
    idx = ((pan + 32768) * (PanD - 1) + PanRound) / 65535;
    idx = clip(idx, 0, PanD - 1);
    gl  = (longint'(pan_tab[PanD - 1 - idx]) * gain) >>> 7;
    gr  = (longint'(pan_tab[idx]) * gain) >>> 7;
  endfunction

  function automatic longint peak_q16(longint v);
    longint a;
    a = (v < 0) ? -v : v;
    if (a > 8388608) a = 8388608;
    return a >> 7;
  endfunction

  function automatic void cfg_apply(cfg_idx_e idx, logic [CfgDataW-1:0] v);
    case (idx)
      CFG_TARGET_GAIN:     tgt_gain   = v[15:0];
      CFG_TARGET_PAN:      tgt_pan    = longint'($signed(v[15:0]));
      CFG_SMOOTH_COEFF:    smooth     = v;
      CFG_METER_DECAY:     decay      = v[15:0];
      CFG_BLOCK_LEN:       blen       = v[12:0];
      CFG_BLOCK_LEN_RECIP: recip      = v;
      CFG_MONO_SOURCE:     mono_src   = v[0];
      CFG_BUS_STEREO:      stereo_bus = v[0];
      default: ;
    endcase
  endfunction

  function automatic mix_result_t mix_predict(step_row_t w);
    mix_result_t res;
    longint l, r, bl, br, vl, vr, ol, orr, len, c, rc, sg, sp, sl, sr, el, er;
    l   = longint'($signed(w.inl));
    r   = mono_src ? l : longint'($signed(w.inr));
    bl  = longint'($signed(w.bl));
    br  = longint'($signed(w.br));
    len = clip(blen, 1, MaxBlockLenDef);

    // block start: smooth gain and pan, then set up the linear ramps
    if (pos_in_block == 0) begin
      c        = clip(smooth, CoeffMin, CoeffMax);
      rc       = clip(recip, 0, RecipMax);
      sg       = gain_now;
      sp       = pan_now;
      gain_now = clip(sg + (((tgt_gain - sg) * c) >>> 16), 0, 65535);
      pan_now  = clip(sp + (((tgt_pan - sp) * c) >>> 16), -32768, 32767);
      pan_pair(sp, sg, sl, sr);
      pan_pair(pan_now, gain_now, el, er);
      ramp_l = sl;
      ramp_r = sr;
      step_l = clip(((el - sl) * rc) >>> 16, -8388608, 8388607);
      step_r = clip(((er - sr) * rc) >>> 16, -8388608, 8388607);
    end

    vl = (l * ramp_l) >>> 22;
    ol = clip(bl + vl, -BusMax - 1, BusMax);
    if (peak_q16(vl) > peak_blk) peak_blk = peak_q16(vl);
    if (stereo_bus) begin
      vr  = (r * ramp_r) >>> 22;
      orr = clip(br + vr, -BusMax - 1, BusMax);
      if (peak_q16(vr) > peak_blk) peak_blk = peak_q16(vr);
    end else begin
      orr = br;
    end

    ramp_l = clip(ramp_l + step_l, 0, 16777215);
    ramp_r = clip(ramp_r + step_r, 0, 16777215);

    res.blk_end = (pos_in_block + 1 >= len);
    if (res.blk_end) begin
      if (clip(peak_blk, 0, 65536) > meter_now) meter_now = clip(peak_blk, 0, 65536);
      else meter_now = (meter_now * clip(decay, DecayMin, DecayMax)) >> 16;
      peak_blk     = 0;
      pos_in_block = 0;
    end else begin
      pos_in_block++;
    end

    res.bus_l = ol[BusW-1:0];
    res.bus_r = orr[BusW-1:0];
    res.meter = meter_now[MeterW-1:0];
    return res;
  endfunction

  function automatic step_row_t item_row(int inl, int inr, int bl, int br,
                                         bit chk = 1'b0, int el = 0, int er = 0,
                                         bit eend = 1'b0, int emtr = 0);
    step_row_t row;
    row              = '0;
    row.kind         = ROW_ITEM;
    row.inl          = inl[SampleW-1:0];
    row.inr          = inr[SampleW-1:0];
    row.bl           = bl[BusW-1:0];
    row.br           = br[BusW-1:0];
    row.chk          = chk;
    row.want.bus_l   = el[BusW-1:0];
    row.want.bus_r   = er[BusW-1:0];
    row.want.blk_end = eend;
    row.want.meter   = emtr[MeterW-1:0];
    return row;
  endfunction

  function automatic step_row_t cfg_row(cfg_idx_e idx, int v);
    step_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.idx     = idx;
    row.cfg_val = v[CfgDataW-1:0];
    return row;
  endfunction

  // full scale at either end of the range, and zero, come up more often than uniform draws give
  function automatic int rnd_field(int w);
    case ($urandom_range(0, 7))
      0:       return (1 <<< (w - 1)) - 1;
      1:       return -(1 <<< (w - 1));
      2:       return 0;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic send_item(step_row_t row);
    mix_result_t pred;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row.br, row.bl, row.inr, row.inl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = mix_predict(row);
    bus_exp_q.push_back(row.chk ? row.want : pred);
  endtask

  // block must be idle before any register write
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (bus_exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v[CfgDataW-1:0];
    cfg_apply(idx, v[CfgDataW-1:0]);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_config(int mode);
    int g, p, c, d, len, rc, mono, st;
    if (mode == 0) begin
      g = 0; p = -32768; c = CoeffMin; d = DecayMin; len = 1; rc = 16; mono = 0; st = 0;
    end else if (mode == 1) begin
      g = 65535; p = 32767; c = CoeffMax; d = DecayMax; len = MaxBlockLenDef;
      rc = RecipMax; mono = 1; st = 1;
    end else begin
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 131071);
      p = $urandom_range(0, 131071);
      case ($urandom_range(0, 4))
        0:       c = $urandom_range(0, 3276);
        1:       c = $urandom_range(65537, 131071);
        default: c = $urandom_range(3277, 65536);
      endcase
      d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                      : $urandom_range(32768, 65470);
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = $urandom_range(4097, 8191);
        2:       len = $urandom_range(13, 600);
        default: len = $urandom_range(1, 12);
      endcase
      rc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                       : int'(65536 / clip(len, 1, MaxBlockLenDef));
      mono = $urandom_range(0, 1);
      st   = $urandom_range(0, 1);
    end
    cfg_write(CFG_TARGET_GAIN, g);
    cfg_write(CFG_TARGET_PAN, p);
    cfg_write(CFG_SMOOTH_COEFF, c);
    cfg_write(CFG_METER_DECAY, d);
    cfg_write(CFG_BLOCK_LEN, len);
    cfg_write(CFG_BLOCK_LEN_RECIP, rc);
    cfg_write(CFG_MONO_SOURCE, mono);
    cfg_write(CFG_BUS_STEREO, st);
  endtask

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

  always @(posedge clk_i) begin : out_check
    mix_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (bus_exp_q.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        want = bus_exp_q.pop_front();
        check_field("bus_left_out", $signed(m_axis_tdata[27:0]), $signed(want.bus_l));
        check_field("bus_right_out", $signed(m_axis_tdata[55:28]), $signed(want.bus_r));
        check_field("meter_level", m_axis_tdata[72:56], want.meter);
        check_field("block_end", m_axis_tlast, want.blk_end);
        check_field("tdata pad", m_axis_tdata[79:73], 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int mode;
    err_cnt       = 0;
    quiet_cycles  = 0;
    send_idle_pct = 29;
    rcv_idle_pct  = 62;
    gain_now = 0; pan_now = 0; ramp_l = 0; ramp_r = 0; step_l = 0; step_r = 0;
    pos_in_block = 0; peak_blk = 0; meter_now = 0;
    build_pan_tab();

    dir_tab = '{
      // fresh out of reset the ramp starts at zero gain: bus words pass unchanged
      item_row(8388607, -8388608, 134217727, -134217728,
               1'b1, 134217727, -134217728, 1'b0, 0),
      item_row(-8388608, 8388607, -134217728, 134217727),
      // length 0 mid-block, oversized ramp factor, coefficient below range
      cfg_row(CFG_BLOCK_LEN, 0),
      cfg_row(CFG_BLOCK_LEN_RECIP, 131071),
      cfg_row(CFG_SMOOTH_COEFF, 0),
      cfg_row(CFG_TARGET_GAIN, 65535),
      cfg_row(CFG_TARGET_PAN, -32768),
      item_row(8388607, 8388607, 134217727, 134217727),
      item_row(-8388608, -8388608, -134217728, -134217728),
      item_row(8388607, -8388608, 0, 0),
      item_row(0, 0, 0, 0),
      // full right, jump to full gain: ramp step and ramp gain both saturate
      cfg_row(CFG_SMOOTH_COEFF, 131071),
      cfg_row(CFG_TARGET_PAN, 32767),
      cfg_row(CFG_BLOCK_LEN, 8),
      item_row(4194304, -4194304, 1000, -1000),
      item_row(-1, 1, 0, 0),
      item_row(8388607, 8388607, -5, 5),
      item_row(-8388608, 12345, 77, -77),
      // shortened while at position 4: next word closes the block
      cfg_row(CFG_BLOCK_LEN, 2),
      item_row(6000000, -6000000, 0, 0),
      item_row(-6000000, 6000000, 0, 0),
      // mono bus, mono source, decay below range
      cfg_row(CFG_BUS_STEREO, 0),
      cfg_row(CFG_MONO_SOURCE, 1),
      cfg_row(CFG_TARGET_GAIN, 32768),
      cfg_row(CFG_METER_DECAY, 0),
      cfg_row(CFG_BLOCK_LEN, 3),
      cfg_row(CFG_BLOCK_LEN_RECIP, 21845),
      item_row(8388607, -8388608, 100, 134217727),
      item_row(-8388608, 0, -100, -134217728),
      item_row(3000000, 0, 0, 1),
      item_row(0, 0, 0, 0),
      // silence with decay above range
      cfg_row(CFG_METER_DECAY, 65535),
      cfg_row(CFG_BUS_STEREO, 1),
      item_row(0, 0, 0, 0),
      item_row(0, 0, 0, 0),
      item_row(0, 0, 0, 0)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].cfg_val);
      end else begin
        send_item(dir_tab[i]);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 62;
        rcv_idle_pct  = 29;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
      end
      mode = (ph == 0) ? 0 : ((ph == 5) ? 1 : 2);
      drain();
      random_config(mode);
      repeat ($urandom_range(100, 180))
        send_item(item_row(rnd_field(SampleW), rnd_field(SampleW),
                           rnd_field(BusW), rnd_field(BusW)));
    end

    drain();
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
